[rtl/pp6_pkg.sv]
// Shared types, constants and codes for the P6 image stream parser.
package pp6_pkg;

  localparam int DIM_BITS = 12;
  localparam int LINE_W   = DIM_BITS + 2;
  localparam int ADDR_W   = 26;
  localparam int ERR_W    = 4;
  localparam int PROD_W   = LINE_W + DIM_BITS;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [DIM_BITS-1:0] MAX_VAL = DIM_BITS'(255);

  localparam logic [ERR_W-1:0] ERR_SHORT      = 4'd0;
  localparam logic [ERR_W-1:0] ERR_MAGIC      = 4'd1;
  localparam logic [ERR_W-1:0] ERR_NEWLINE    = 4'd2;
  localparam logic [ERR_W-1:0] ERR_DIGIT      = 4'd3;
  localparam logic [ERR_W-1:0] ERR_WIDTH0     = 4'd4;
  localparam logic [ERR_W-1:0] ERR_HEIGHT0    = 4'd5;
  localparam logic [ERR_W-1:0] ERR_NPOT       = 4'd6;
  localparam logic [ERR_W-1:0] ERR_MAX0       = 4'd7;
  localparam logic [ERR_W-1:0] ERR_MAX255     = 4'd8;
  localparam logic [ERR_W-1:0] ERR_DATA_SHORT = 4'd9;

  typedef enum logic [7:0] {
    PH_P    = 8'b0000_0001,
    PH_6    = 8'b0000_0010,
    PH_NL   = 8'b0000_0100,
    PH_W    = 8'b0000_1000,
    PH_H    = 8'b0001_0000,
    PH_MAX  = 8'b0010_0000,
    PH_DATA = 8'b0100_0000,
    PH_HALT = 8'b1000_0000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [ADDR_W-1:0]   addr;
    logic [7:0]          value;
    logic                last;
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
    logic [ERR_W-1:0]    err;
  } res_t;

endpackage

[rtl/pp6_parse.sv]
// Header parser, pixel address generator and configuration register.
module pp6_parse
  import pp6_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       step,
  input  logic [7:0] byte_in,
  input  logic       end_in,
  output logic       res_vld,
  output res_t       res
);

  phase_t              phase_r, phase_nxt;
  logic [DIM_BITS-1:0] acc_r, acc_nxt;
  logic [DIM_BITS-1:0] width_r, width_nxt;
  logic [DIM_BITS-1:0] height_r, height_nxt;
  logic [LINE_W-1:0]   line_r, line_nxt;
  logic [ADDR_W-1:0]   base_r, base_nxt;
  logic [LINE_W-1:0]   col_r, col_nxt;
  logic [DIM_BITS-1:0] rows_r, rows_nxt;
  logic                npot_r;

  logic                is_digit;
  logic [DIM_BITS+3:0] acc_x10;
  logic [DIM_BITS+3:0] acc_new;
  logic                dig_ok;
  logic [LINE_W:0]     col_inc;
  logic                row_done;
  logic                last_px;
  logic [PROD_W-1:0]   base_prod;

  function automatic logic pow2(input logic [DIM_BITS-1:0] x);
    pow2 = (x != '0) && ((x & (x - 1'b1)) == '0);
  endfunction

  assign is_digit  = (byte_in >= CH_0) && (byte_in <= CH_9);
  assign acc_x10   = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0};
  assign acc_new   = acc_x10 + {{(DIM_BITS){1'b0}}, 4'(byte_in - CH_0)};
  assign dig_ok    = is_digit && (acc_new[DIM_BITS+3:DIM_BITS] == '0);
  assign col_inc   = {1'b0, col_r} + 1'b1;
  assign row_done  = col_inc >= {1'b0, line_r};
  assign last_px   = row_done && (rows_r <= DIM_BITS'(1));
  // one multiply, only looked at while waiting for the max value
  assign base_prod = PROD_W'(line_r) * PROD_W'(height_r - 1'b1);

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    line_nxt   = line_r;
    base_nxt   = base_r;
    col_nxt    = col_r;
    rows_nxt   = rows_r;
    res_vld    = 1'b0;
    res        = '0;
    res.kind   = KIND_ERROR;

    if (end_in) begin
      case (phase_r)
        PH_6, PH_NL, PH_W, PH_H, PH_MAX: begin
          res_vld = 1'b1;
          res.err = ERR_SHORT;
        end
        PH_DATA: begin
          res_vld = 1'b1;
          res.err = ERR_DATA_SHORT;
        end
        default: ;
      endcase
      phase_nxt = PH_P;
    end else begin
      case (phase_r)
        PH_P: begin
          if (byte_in != CH_P) begin
            res_vld = 1'b1; res.err = ERR_MAGIC; phase_nxt = PH_HALT;
          end else begin
            phase_nxt = PH_6;
          end
        end
        PH_6: begin
          if (byte_in != CH_6) begin
            res_vld = 1'b1; res.err = ERR_MAGIC; phase_nxt = PH_HALT;
          end else begin
            phase_nxt = PH_NL;
          end
        end
        PH_NL: begin
          if (byte_in != CH_NL) begin
            res_vld = 1'b1; res.err = ERR_NEWLINE; phase_nxt = PH_HALT;
          end else begin
            acc_nxt   = '0;
            phase_nxt = PH_W;
          end
        end
        PH_W: begin
          if (byte_in == CH_SPACE) begin
            if (acc_r == '0) begin
              res_vld = 1'b1; res.err = ERR_WIDTH0; phase_nxt = PH_HALT;
            end else begin
              width_nxt = acc_r;
              line_nxt  = {2'b00, acc_r} + {1'b0, acc_r, 1'b0};
              acc_nxt   = '0;
              phase_nxt = PH_H;
            end
          end else if (!dig_ok) begin
            res_vld = 1'b1; res.err = ERR_DIGIT; phase_nxt = PH_HALT;
          end else begin
            acc_nxt = acc_new[DIM_BITS-1:0];
          end
        end
        PH_H: begin
          if (byte_in == CH_NL) begin
            if (acc_r == '0) begin
              res_vld = 1'b1; res.err = ERR_HEIGHT0; phase_nxt = PH_HALT;
            end else begin
              height_nxt = acc_r;
              acc_nxt    = '0;
              if (!npot_r && (!pow2(width_r) || !pow2(acc_r))) begin
                res_vld = 1'b1; res.err = ERR_NPOT; phase_nxt = PH_HALT;
              end else begin
                phase_nxt = PH_MAX;
              end
            end
          end else if (!dig_ok) begin
            res_vld = 1'b1; res.err = ERR_DIGIT; phase_nxt = PH_HALT;
          end else begin
            acc_nxt = acc_new[DIM_BITS-1:0];
          end
        end
        PH_MAX: begin
          if (byte_in == CH_NL) begin
            if (acc_r == '0) begin
              res_vld = 1'b1; res.err = ERR_MAX0; phase_nxt = PH_HALT;
            end else if (acc_r != MAX_VAL) begin
              res_vld = 1'b1; res.err = ERR_MAX255; phase_nxt = PH_HALT;
            end else begin
              acc_nxt    = '0;
              base_nxt   = ADDR_W'(base_prod);
              col_nxt    = '0;
              rows_nxt   = height_r;
              phase_nxt  = PH_DATA;
              res_vld    = 1'b1;
              res.kind   = KIND_HEADER;
              res.width  = width_r;
              res.height = height_r;
            end
          end else if (!dig_ok) begin
            res_vld = 1'b1; res.err = ERR_DIGIT; phase_nxt = PH_HALT;
          end else begin
            acc_nxt = acc_new[DIM_BITS-1:0];
          end
        end
        PH_DATA: begin
          res_vld   = 1'b1;
          res.kind  = KIND_PIXEL;
          res.addr  = base_r + ADDR_W'(col_r);
          res.value = byte_in;
          res.last  = last_px;
          if (row_done) begin
            // step down one row: frame rows are stored bottom-up
            col_nxt = '0;
            if (rows_r != '0) begin
              rows_nxt = rows_r - 1'b1;
            end
            base_nxt = (base_r >= ADDR_W'(line_r)) ? base_r - ADDR_W'(line_r) : '0;
          end else begin
            col_nxt = col_inc[LINE_W-1:0];
          end
          if (last_px) begin
            phase_nxt = PH_P;
          end
        end
        PH_HALT: ;
        default: phase_nxt = PH_P;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_P;
      acc_r    <= '0;
      width_r  <= '0;
      height_r <= '0;
      line_r   <= '0;
      base_r   <= '0;
      col_r    <= '0;
      rows_r   <= '0;
      npot_r   <= 1'b0;
    end else begin
      if (step) begin
        phase_r  <= phase_nxt;
        acc_r    <= acc_nxt;
        width_r  <= width_nxt;
        height_r <= height_nxt;
        line_r   <= line_nxt;
        base_r   <= base_nxt;
        col_r    <= col_nxt;
        rows_r   <= rows_nxt;
      end
      if (cfg_we) begin
        npot_r <= cfg_wdata;
      end
    end
  end

  a_err_stops: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_vld && res.kind == KIND_ERROR |=> phase_r == PH_HALT || phase_r == PH_P)
    else $error("error beat did not halt or idle the parser");

  a_hdr_loads: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_vld && res.kind == KIND_HEADER |=> phase_r == PH_DATA && rows_r == height_r
      && col_r == '0)
    else $error("header accept did not set up the pixel counters");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> col_r < line_r)
    else $error("column count ran past the line length");

  a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
    step && !end_in && phase_r == PH_DATA && last_px |=> phase_r == PH_P)
    else $error("parser did not return to idle after the last pixel");

endmodule

[rtl/pp6_out_reg.sv]
// Result register on the master side of the parser.
module pp6_out_reg
  import pp6_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res_in,
  input  logic take,
  output logic free,
  output logic vld,
  output res_t res_out
);

  logic vld_r, vld_nxt;
  res_t res_r;

  assign free    = !vld_r || take;
  assign vld     = vld_r;
  assign res_out = res_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("result loaded over an unsent beat");

endmodule

[rtl/ppm_p6_stream_parser.sv]
// Top level of the P6 image stream parser: input register, parser, result register.
//
// Slave side in_*: one byte of a binary P6 image per beat; in_tlast marks an
// end-of-stream beat whose byte is ignored. The header must be "P6", newline,
// width digits, space, height digits, newline, max value 255, newline.
// Master side out_*: at most one beat per input beat. out_tuser gives the kind
// (pixel, header accepted, error); out_tlast flags the final pixel byte.
// Pixel beats carry the byte and its frame-store address, rows bottom-up.
// After an error the parser drops bytes until an end-of-stream beat.
// cfg_we writes cfg_wdata (1 accepts non-power-of-two sizes); write it only
// while the block is idle.
// A result passes through the input register and then the result register.
// Throughput: one byte per cycle while the receiver takes results, set by
// the combinational parse step between the two registers.
// Reset: parser waits for 'P', non-power-of-two sizes are rejected.
// When the receiver stalls, the input register holds one more beat and then
// in_tready drops until the result is taken.
module ppm_p6_stream_parser
  import pp6_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // stream_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [25:0] pixel_address, [33:26] pixel_value,
                                  // [45:34] image_width, [57:46] image_height,
                                  // [61:58] error_code, [63:62] zero
  output logic [1:0]  out_tuser,  // [1:0] result_kind
  output logic        out_tlast   // last_pixel
);

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       in_end_r;
  logic       in_acc;
  logic       adv;
  logic       out_free;
  logic       res_vld;
  res_t       res;
  res_t       out_res;

  assign adv       = in_vld_r && out_free;
  assign in_tready = !in_vld_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
  end

  pp6_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .step     (adv),
    .byte_in  (in_byte_r),
    .end_in   (in_end_r),
    .res_vld  (res_vld),
    .res      (res)
  );

  pp6_out_reg u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (adv && res_vld),
    .res_in (res),
    .take   (out_tready),
    .free   (out_free),
    .vld    (out_tvalid),
    .res_out(out_res)
  );

  assign out_tdata = {2'b00, out_res.err, out_res.height, out_res.width,
                      out_res.value, out_res.addr};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule
